### rtl/ammgs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ammgs_pkg
// Shared types and constants for the four-by-four matrix mixer with gain
// smoothing.
// ----------------------------------------------------------------------------
package ammgs_pkg;

    // default build
    localparam int AMMGS_INPUT_CHANNELS  = 4;
    localparam int AMMGS_OUTPUT_CHANNELS = 4;
    localparam int AMMGS_CHUNK           = 32;
    localparam int AMMGS_SAMPLE_BITS     = 24;

    // fixed field widths
    localparam int SMP_W     = 24;   // sample field
    localparam int GAIN_W    = 24;   // signed Q3.20
    localparam int GAIN_FRAC = 20;
    localparam int CUR_W     = 32;   // running gain; creeps past Q3.20 top at zero coefficient
    localparam int COEF_W    = 16;   // unsigned Q0.16
    localparam int COEF_FRAC = 16;
    localparam int SNAP_W    = 10;
    localparam int CH_MAX    = 4;
    localparam int SLOTS     = 16;
    localparam int SLOT_W    = 4;
    localparam int CNT_W     = 6;

    // stream and config widths
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 96;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_COEF = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_LIMIT     = 8'd1;

    localparam logic [COEF_W-1:0] COEF_RESET = 16'd1256;
    localparam logic [SNAP_W-1:0] SNAP_RESET = 10'd1;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_GAIN  = 1'b1
    } op_t;

endpackage : ammgs_pkg
`default_nettype wire

### rtl/audio_matrix_mixer_gain_smoothing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// audio_matrix_mixer_gain_smoothing
// Mixes up to four input channels into up to four outputs through a 4x4
// gain matrix, with one-pole smoothing of each gain toward its target.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tdata: in_ch0..3, gain_slot, gain_value;
//           |           | tuser: operation; tlast: period_end
//  m_axis   | out       | tdata: out_ch0..3 (one per audio frame)
//  cfg      | in        | cfg_index, cfg_data; always ready
//
// One item per cycle while m_tready holds no frame back; an audio frame
// passes the input register and then the result register before it shows
// on m_tvalid. The rate is set by the parallel mix multipliers (16) and the
// parallel smoothing multipliers (16), each between two registers. A gain
// write gives no result. Reset clears all gains, targets and the frame
// counter and loads the default coefficient and snap limit.
// With m_tready low the result holds and one more item waits in the input
// register; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module audio_matrix_mixer_gain_smoothing
    import ammgs_pkg::*;
#(
    parameter int INPUT_CHANNELS  = AMMGS_INPUT_CHANNELS,
    parameter int OUTPUT_CHANNELS = AMMGS_OUTPUT_CHANNELS,
    parameter int CHUNK           = AMMGS_CHUNK,
    parameter int SAMPLE_BITS     = AMMGS_SAMPLE_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [23:0] in_ch0, [47:24] in_ch1, [71:48] in_ch2, [95:72] in_ch3,
    // [99:96] gain_slot, [123:100] gain_value, [127:124] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,   // [0] operation
    input  wire logic                 s_tlast,   // period_end
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [23:0] out_ch0, [47:24] out_ch1, [71:48] out_ch2, [95:72] out_ch3
    output logic [M_TDATA_W-1:0]      m_tdata,
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int SBITS  = (SAMPLE_BITS > SMP_W) ? SMP_W : SAMPLE_BITS;
    localparam int ACC_W  = SMP_W + CUR_W + 2;
    localparam int DIFF_W = CUR_W + 1;
    localparam int PROD_W = COEF_W + 1 + DIFF_W;
    localparam int STEP_W = PROD_W - COEF_FRAC;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    // input register
    logic                       in_valid_reg;
    op_t                        in_op_reg;
    logic                       in_last_reg;
    logic [CH_MAX-1:0][SMP_W-1:0] in_smp_reg;
    logic [SLOT_W-1:0]          in_slot_reg;
    logic [GAIN_W-1:0]          in_gval_reg;

    // result register
    logic                       out_valid_reg;
    logic [M_TDATA_W-1:0]       out_data_reg;
    logic [M_TDATA_W-1:0]       out_data_next;

    // state
    logic [SLOTS-1:0][CUR_W-1:0]  cur_gain_reg;
    logic [SLOTS-1:0][CUR_W-1:0]  cur_gain_next;
    logic [SLOTS-1:0][GAIN_W-1:0] tgt_gain_reg;
    logic [CNT_W-1:0]           chunk_cnt_reg;
    logic [CNT_W-1:0]           chunk_cnt_next;
    logic [COEF_W-1:0]          coef_reg;
    logic [SNAP_W-1:0]          snap_reg;

    logic s_xfer;
    logic advance;
    logic frame_go;
    logic write_go;
    logic smooth_en;

    assign s_xfer    = s_tvalid && s_tready;
    assign advance   = in_valid_reg &&
                       ((in_op_reg == OP_GAIN) || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign frame_go  = advance && (in_op_reg == OP_FRAME);
    assign write_go  = advance && (in_op_reg == OP_GAIN);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign chunk_cnt_next = chunk_cnt_reg + CNT_W'(1);
    assign smooth_en = frame_go && ((chunk_cnt_next >= CNT_W'(CHUNK)) || in_last_reg);

    // mix: one multiplier per crosspoint, adder tree per column, floor, clamp
    always_comb begin
        logic signed [SMP_W-1:0] smp_ext [CH_MAX];
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] y;
        for (int r = 0; r < CH_MAX; r++) begin
            smp_ext[r] = SMP_W'(signed'(in_smp_reg[r][SBITS-1:0]));
        end
        out_data_next = '0;
        for (int c = 0; c < CH_MAX; c++) begin
            acc = '0;
            for (int r = 0; r < CH_MAX; r++) begin
                if (r < INPUT_CHANNELS) begin
                    acc = acc + ACC_W'(smp_ext[r]) *
                                ACC_W'(signed'(cur_gain_reg[r * CH_MAX + c]));
                end
            end
            y = acc >>> GAIN_FRAC;
            if (y > SAT_HI) begin
                y = SAT_HI;
            end
            if (y < SAT_LO) begin
                y = SAT_LO;
            end
            if (c < OUTPUT_CHANNELS) begin
                out_data_next[c*SMP_W +: SMP_W] = y[SMP_W-1:0];
            end
        end
    end

    // smoothing step for every slot in parallel
    always_comb begin
        logic signed [DIFF_W-1:0] diff;
        logic signed [DIFF_W-1:0] diff_abs;
        logic signed [PROD_W-1:0] prod;
        logic signed [STEP_W-1:0] step;
        logic signed [STEP_W-1:0] sum;
        for (int i = 0; i < SLOTS; i++) begin
            diff     = DIFF_W'(signed'(tgt_gain_reg[i])) -
                       DIFF_W'(signed'(cur_gain_reg[i]));
            diff_abs = diff[DIFF_W-1] ? -diff : diff;
            prod     = PROD_W'(signed'({1'b0, coef_reg})) * PROD_W'(diff);
            step     = prod[PROD_W-1:COEF_FRAC];
            if (step == '0) begin
                step = STEP_W'(1);
            end
            sum = STEP_W'(signed'(cur_gain_reg[i])) + step;
            if (diff_abs <= DIFF_W'(snap_reg)) begin
                cur_gain_next[i] = CUR_W'(signed'(tgt_gain_reg[i]));
            end else begin
                cur_gain_next[i] = sum[CUR_W-1:0];
            end
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_op_reg   <= op_t'(s_tuser);
            in_last_reg <= s_tlast;
            for (int r = 0; r < CH_MAX; r++) begin
                in_smp_reg[r] <= s_tdata[r*SMP_W +: SMP_W];
            end
            in_slot_reg <= s_tdata[CH_MAX*SMP_W +: SLOT_W];
            in_gval_reg <= s_tdata[CH_MAX*SMP_W + SLOT_W +: GAIN_W];
        end
        if (frame_go) begin
            out_data_reg <= out_data_next;
        end
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chunk_cnt_reg <= '0;
            cur_gain_reg  <= '0;
            tgt_gain_reg  <= '0;
            coef_reg      <= COEF_RESET;
            snap_reg      <= SNAP_RESET;
        end else begin
            if (s_xfer) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (frame_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (write_go) begin
                tgt_gain_reg[in_slot_reg] <= in_gval_reg;
            end

            if (smooth_en) begin
                chunk_cnt_reg <= '0;
                cur_gain_reg  <= cur_gain_next;
            end else if (frame_go) begin
                chunk_cnt_reg <= chunk_cnt_next;
            end

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_SMOOTHING_COEF: coef_reg <= cfg_data[COEF_W-1:0];
                    CFG_SNAP_LIMIT:     snap_reg <= cfg_data[SNAP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    // a result appears only from an audio frame leaving the input register
    a_result_from_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(out_valid_reg) |-> $past(frame_go))
        else $error("result raised without an audio frame");

    // counter never reaches the chunk length
    a_chunk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        chunk_cnt_reg < CNT_W'(CHUNK))
        else $error("frame counter out of range");

    // current gains move only on a smoothing step
    a_gain_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(smooth_en) |-> cur_gain_reg == $past(cur_gain_reg))
        else $error("current gain changed outside a smoothing step");

    // a ready input side with a held item means that item moves on
    a_ready_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && in_valid_reg |-> advance)
        else $error("input ready while held item is stalled");
`endif

endmodule : audio_matrix_mixer_gain_smoothing
`default_nettype wire
